### design/cct_pkg.sv
`default_nettype none

package cct_pkg;

   // Parser phases.
   typedef enum logic [3:0] {
      PH_START,
      PH_NAME,
      PH_AFTER_NAME,
      PH_ARG,
      PH_BARE,
      PH_AFTER_TOK,
      PH_STR,
      PH_STR_ESC,
      PH_STR_HEX0,
      PH_STR_HEX1,
      PH_CHR_OPEN,
      PH_CHR_ESC,
      PH_CHR_HEX0,
      PH_CHR_HEX1,
      PH_CHR_CLOSE,
      PH_IDLE
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // Error codes.
   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_EMPTY        = 4'd1;
   localparam logic [3:0] ERR_NO_PAREN     = 4'd2;
   localparam logic [3:0] ERR_NO_CLOSE     = 4'd3;
   localparam logic [3:0] ERR_TOO_MANY     = 4'd4;
   localparam logic [3:0] ERR_OPEN_STRING  = 4'd5;
   localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
   localparam logic [3:0] ERR_EMPTY_CHAR   = 4'd7;
   localparam logic [3:0] ERR_BAD_CHAR     = 4'd8;

   // Characters with a meaning to the parser.
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_OPEN      = 8'h28;
   localparam logic [7:0] CH_CLOSE     = 8'h29;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_X         = 8'h78;

   localparam logic [3:0] MAX_ARGS_RESET = 4'd10;

   // One input byte causes at most this many results.
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [3:0] token_index;
      logic [3:0] error_code;
      logic [4:0] arg_total;
      logic       last_of_run;
   } rsp_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [RCNT_W-1:0]               count;
      rsp_type [MAX_RESULTS-1:0]       items;
   } run_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

   // Bit 4 is set when the byte is a hex digit; bits 3:0 hold its value.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {["0":"9"]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {["a":"f"]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {["A":"F"]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         "n":     r = 8'h0A;
         "r":     r = 8'h0D;
         "t":     r = 8'h09;
         "0":     r = 8'h00;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [3:0] err, input logic [4:0] cnt);
      rsp_type r;
      r.kind        = kind;
      r.data_byte   = (kind == KIND_BYTE) ? data : 8'd0;
      r.token_index = ((kind == KIND_BYTE || kind == KIND_END) && cnt != 5'd0)
                      ? 4'(cnt - 5'd1) : 4'd0;
      r.error_code  = err;
      r.arg_total   = (kind == KIND_DONE) ? cnt : 5'd0;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

### design/command_call_tokenizer.sv
// Command line tokenizer.
// The req channel carries one byte of a command line per transfer
// (req_char_in), or an end-of-line marker (req_is_end high, byte ignored).
// The rsp channel returns token bytes, token ends, a done result with the
// token count, or an error code; rsp_last_of_run marks the last result
// caused by one input transfer. One input causes zero to two results.
// The csr channel writes max_args; csr_ready is always high, and writes are
// meant to happen only while no results are pending.
// Results are registered in a queue before they are offered on rsp.
// Throughput: one input byte per cycle while rsp is not stalled and each
// byte yields at most one result; rsp delivers one result per unstalled
// cycle, and a four-entry result queue throttles req (req_stall) when more
// than one result waits. A receiver stall holds the queue head on rsp and
// fills the queue, which then stalls req. Reset (synchronous) returns the
// parser to its start phase, empties the queue and sets max_args to 10.
`default_nettype none

module command_call_tokenizer
   import cct_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_is_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [3:0]      rsp_token_index,
   output logic [3:0]      rsp_error_code,
   output logic [4:0]      rsp_arg_total,
   output logic            rsp_last_of_run,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_max_args
);

   logic [3:0] max_args_ff;
   logic       req_take;
   logic       rsp_take;
   logic       has_room;
   run_type    run;
   rsp_type    head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= MAX_ARGS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_args_ff <= csr_max_args;
      end
   end

   assign req_stall = !has_room;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   cct_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_take),
      .char_in  (req_char_in),
      .is_end   (req_is_end),
      .max_args (max_args_ff),
      .run      (run)
   );

   cct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .run       (run),
      .pop       (rsp_take),
      .head      (head),
      .not_empty (rsp_valid),
      .has_room  (has_room)
   );

   assign rsp_kind        = head.kind;
   assign rsp_data_byte   = head.data_byte;
   assign rsp_token_index = head.token_index;
   assign rsp_error_code  = head.error_code;
   assign rsp_arg_total   = head.arg_total;
   assign rsp_last_of_run = head.last_of_run;

   a_err_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_error_code != ERR_NONE)
      else $error("error result without a code");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_ERROR) |-> rsp_last_of_run)
      else $error("done or error result not last of its run");

endmodule

`default_nettype wire

### design/cct_parser.sv
`default_nettype none

module cct_parser
   import cct_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] char_in,
   input  wire logic       is_end,
   input  wire logic [3:0] max_args,
   output run_type         run
);

   phase_type  phase_ff, phase_in, ph;
   logic [4:0] count_ff, count_in;
   logic [3:0] escape_ff, escape_in;
   logic       saw_open_ff, saw_open_in;
   logic [4:0] hx;
   logic       go;
   logic [RCNT_W-1:0] n;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         count_ff    <= 5'd0;
         escape_ff   <= 4'd0;
         saw_open_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         escape_ff   <= escape_in;
         saw_open_ff <= saw_open_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      escape_in   = escape_ff;
      saw_open_in = saw_open_ff;
      run         = '0;
      n           = '0;
      ph          = phase_ff;
      go          = 1'b0;
      hx          = hex_val(char_in);

      if (is_end) begin
         case (phase_ff)
            PH_START: begin
               run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_EMPTY, count_ff);
               n = n + 1'b1;
            end
            PH_NAME: begin
               run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_NO_PAREN, count_ff);
               n = n + 1'b1;
            end
            PH_AFTER_NAME: begin
               run.items[n] = make_rsp(KIND_ERROR, 8'd0,
                                       saw_open_ff ? ERR_NO_CLOSE : ERR_NO_PAREN, count_ff);
               n = n + 1'b1;
            end
            PH_STR, PH_STR_ESC, PH_STR_HEX0, PH_STR_HEX1: begin
               run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_OPEN_STRING, count_ff);
               n = n + 1'b1;
            end
            PH_IDLE: begin
            end
            default: begin
               run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_NO_CLOSE, count_ff);
               n = n + 1'b1;
            end
         endcase
         phase_in    = PH_START;
         count_in    = 5'd0;
         escape_in   = 4'd0;
         saw_open_in = 1'b0;
      end else begin
         // A byte is taken up at most twice: once in its phase, and again
         // in the phase that the first pass hands it on to.
         go = 1'b1;
         for (int k = 0; k < 2; k++) begin
            if (go) begin
               go = 1'b0;
               case (ph)
                  PH_START: begin
                     if (!is_ws(char_in)) begin
                        count_in = 5'd1;
                        if (char_in == CH_OPEN) begin
                           run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                           n = n + 1'b1;
                           saw_open_in = 1'b1;
                           phase_in    = PH_AFTER_NAME;
                        end else begin
                           run.items[n] = make_rsp(KIND_BYTE, char_in, ERR_NONE, count_in);
                           n = n + 1'b1;
                           phase_in = PH_NAME;
                        end
                     end
                  end
                  PH_NAME: begin
                     if (char_in == CH_SPACE || char_in == CH_TAB || char_in == CH_OPEN) begin
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        saw_open_in = (char_in == CH_OPEN);
                        phase_in    = PH_AFTER_NAME;
                     end else begin
                        run.items[n] = make_rsp(KIND_BYTE, char_in, ERR_NONE, count_in);
                        n = n + 1'b1;
                     end
                  end
                  PH_AFTER_NAME: begin
                     if (!is_ws(char_in)) begin
                        if (char_in == CH_OPEN) begin
                           phase_in = PH_ARG;
                        end else if (!saw_open_in) begin
                           run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_NO_PAREN, count_in);
                           n = n + 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_ARG;
                           go       = 1'b1;
                        end
                     end
                  end
                  PH_ARG: begin
                     if (is_ws(char_in)) begin
                     end else if (char_in == CH_CLOSE) begin
                        run.items[n] = make_rsp(KIND_DONE, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end else if (count_in > {1'b0, max_args}) begin
                        run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_TOO_MANY, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        count_in = count_in + 5'd1;
                        if (char_in == CH_DQUOTE) begin
                           phase_in = PH_STR;
                        end else if (char_in == CH_SQUOTE) begin
                           phase_in = PH_CHR_OPEN;
                        end else if (char_in == CH_COMMA) begin
                           run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                           n = n + 1'b1;
                        end else begin
                           run.items[n] = make_rsp(KIND_BYTE, char_in, ERR_NONE, count_in);
                           n = n + 1'b1;
                           phase_in = PH_BARE;
                        end
                     end
                  end
                  PH_BARE: begin
                     if (char_in == CH_SPACE || char_in == CH_TAB) begin
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_AFTER_TOK;
                     end else if (char_in == CH_COMMA) begin
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_ARG;
                     end else if (char_in == CH_CLOSE) begin
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        run.items[n] = make_rsp(KIND_DONE, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        run.items[n] = make_rsp(KIND_BYTE, char_in, ERR_NONE, count_in);
                        n = n + 1'b1;
                     end
                  end
                  PH_AFTER_TOK: begin
                     if (!is_ws(char_in)) begin
                        phase_in = PH_ARG;
                        go       = (char_in != CH_COMMA);
                     end
                  end
                  PH_STR: begin
                     if (char_in == CH_DQUOTE) begin
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_AFTER_TOK;
                     end else if (char_in == CH_BACKSLASH) begin
                        phase_in = PH_STR_ESC;
                     end else begin
                        run.items[n] = make_rsp(KIND_BYTE, char_in, ERR_NONE, count_in);
                        n = n + 1'b1;
                     end
                  end
                  PH_STR_ESC: begin
                     if (char_in == CH_X) begin
                        phase_in = PH_STR_HEX0;
                     end else begin
                        run.items[n] = make_rsp(KIND_BYTE, unescape(char_in), ERR_NONE,
                                                count_in);
                        n = n + 1'b1;
                        phase_in = PH_STR;
                     end
                  end
                  PH_STR_HEX0, PH_CHR_HEX0: begin
                     if (!hx[4]) begin
                        run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_BAD_HEX, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        escape_in = hx[3:0];
                        phase_in  = (ph == PH_STR_HEX0) ? PH_STR_HEX1 : PH_CHR_HEX1;
                     end
                  end
                  PH_STR_HEX1: begin
                     phase_in = PH_STR;
                     if (hx[4]) begin
                        run.items[n] = make_rsp(KIND_BYTE, {escape_in, hx[3:0]}, ERR_NONE,
                                                count_in);
                        n = n + 1'b1;
                     end else begin
                        // One hex digit only: the byte is read again as string text.
                        run.items[n] = make_rsp(KIND_BYTE, {4'd0, escape_in}, ERR_NONE,
                                                count_in);
                        n = n + 1'b1;
                        go = 1'b1;
                     end
                  end
                  PH_CHR_OPEN: begin
                     if (char_in == CH_SQUOTE) begin
                        run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_EMPTY_CHAR, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end else if (char_in == CH_BACKSLASH) begin
                        phase_in = PH_CHR_ESC;
                     end else begin
                        run.items[n] = make_rsp(KIND_BYTE, char_in, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_CHR_CLOSE;
                     end
                  end
                  PH_CHR_ESC: begin
                     if (char_in == CH_X) begin
                        phase_in = PH_CHR_HEX0;
                     end else begin
                        run.items[n] = make_rsp(KIND_BYTE, unescape(char_in), ERR_NONE,
                                                count_in);
                        n = n + 1'b1;
                        phase_in = PH_CHR_CLOSE;
                     end
                  end
                  PH_CHR_HEX1: begin
                     if (hx[4]) begin
                        run.items[n] = make_rsp(KIND_BYTE, {escape_in, hx[3:0]}, ERR_NONE,
                                                count_in);
                        n = n + 1'b1;
                        phase_in = PH_CHR_CLOSE;
                     end else if (char_in == CH_SQUOTE) begin
                        run.items[n] = make_rsp(KIND_BYTE, {4'd0, escape_in}, ERR_NONE,
                                                count_in);
                        n = n + 1'b1;
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_AFTER_TOK;
                     end else begin
                        run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_BAD_CHAR, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_CHR_CLOSE: begin
                     if (char_in == CH_SQUOTE) begin
                        run.items[n] = make_rsp(KIND_END, 8'd0, ERR_NONE, count_in);
                        n = n + 1'b1;
                        phase_in = PH_AFTER_TOK;
                     end else begin
                        run.items[n] = make_rsp(KIND_ERROR, 8'd0, ERR_BAD_CHAR, count_in);
                        n = n + 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
               ph = phase_in;
            end
         end
      end

      if (n != '0) begin
         run.items[n - 1'b1].last_of_run = 1'b1;
      end
      run.count = n;
   end

   // An end marker always brings the parser back to the start of a line.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && is_end |=> phase_ff == PH_START && count_ff == 5'd0)
      else $error("end marker did not restart the parser");

   // Token count never goes past the name plus fifteen arguments.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 5'd16)
      else $error("token count out of range");

endmodule

`default_nettype wire

### design/cct_queue.sv
`default_nettype none

module cct_queue
   import cct_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire run_type   run,
   input  wire logic      pop,
   output rsp_type        head,
   output logic           not_empty,
   output logic           has_room
);

   rsp_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] push_n;

   assign push_n    = push ? QCNT_W'(run.count) : '0;
   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + push_n - QCNT_W'(pop);

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   // Room for a full run of results, whatever leaves this cycle.
   assign has_room  = (count_ff <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (push && QCNT_W'(i) < push_n) begin
            entry_ff[wr_ptr_ff + QPTR_W'(i)] <= run.items[i];
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff + push_n <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue underflow");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import cct_pkg::*;

   typedef struct packed {
      logic [7:0] c;
      logic       e;
   } line_byte_type;

   // One row of the directed script; want is used only where typed is set.
   typedef struct packed {
      logic [7:0] c;
      logic       e;
      logic       typed;
      rsp_type    want;
   } script_row_type;

   localparam script_row_type SCRIPT [36] = '{
      '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 4'd0, ERR_EMPTY, 5'd0, 1'b1}},
      '{CH_OPEN, 1'b0, 1'b1, '{KIND_END, 8'h00, 4'd0, ERR_NONE, 5'd0, 1'b1}},
      '{CH_OPEN, 1'b0, 1'b0, '0},
      '{CH_COMMA, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{CH_BACKSLASH, 1'b0, 1'b0, '0},
      '{CH_X, 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0},
      '{"g", 1'b0, 1'b0, '0},
      '{CH_BACKSLASH, 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{CH_CLOSE, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{CH_TAB, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b1, '{KIND_ERROR, 8'h00, 4'd0, ERR_NO_PAREN, 5'd0, 1'b1}},
      '{8'h55, 1'b1, 1'b0, '0},
      '{"a", 1'b0, 1'b0, '0},
      '{CH_OPEN, 1'b0, 1'b0, '0},
      '{CH_SQUOTE, 1'b0, 1'b0, '0},
      '{CH_BACKSLASH, 1'b0, 1'b0, '0},
      '{CH_X, 1'b0, 1'b0, '0},
      '{"z", 1'b0, 1'b1, '{KIND_ERROR, 8'h00, 4'd0, ERR_BAD_HEX, 5'd0, 1'b1}},
      '{8'hAA, 1'b1, 1'b0, '0},
      '{CH_OPEN, 1'b0, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 4'd0, ERR_OPEN_STRING, 5'd0, 1'b1}},
      '{CH_OPEN, 1'b0, 1'b0, '0},
      '{CH_SQUOTE, 1'b0, 1'b0, '0},
      '{"q", 1'b0, 1'b0, '0},
      '{"r", 1'b0, 1'b1, '{KIND_ERROR, 8'h00, 4'd0, ERR_BAD_CHAR, 5'd0, 1'b1}},
      '{8'h7F, 1'b1, 1'b0, '0},
      '{CH_OPEN, 1'b0, 1'b0, '0},
      '{"k", 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 4'd0, ERR_NO_CLOSE, 5'd0, 1'b1}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_is_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_token_index;
   logic [3:0] rsp_error_code;
   logic [4:0] rsp_arg_total;
   logic       rsp_last_of_run;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_max_args = 4'd0;

   // Typed expectation that travels with the item on the request channel.
   logic       cur_typed = 1'b0;
   rsp_type    cur_want = '0;
   logic       steady = 1'b0;

   // Tokenizer state as the testbench predicts it.
   phase_type  ph;
   logic [4:0] tok_cnt;
   logic [7:0] hex_acc;
   logic       paren_seen;
   logic [3:0] arg_limit;
   rsp_type    step_res [0:MAX_RESULTS-1];
   int         step_n;

   rsp_type       token_stream_q [$];
   line_byte_type line_q [$];
   int            mismatches = 0;
   int            sent = 0;

   command_call_tokenizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_is_end      (req_is_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_error_code  (rsp_error_code),
      .rsp_arg_total   (rsp_arg_total),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_args    (csr_max_args)
   );

   always #6 clock = ~clock;

   initial begin
      #2000000;
      $display("FAIL command_call_tokenizer");
      $finish;
   end

   function automatic logic blank_byte(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // Returns {is_digit, value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, c[3:0]};
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         return {1'b1, c[3:0] + 4'd9};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] escape_byte(input logic [7:0] c);
      case (c)
         "n": return 8'h0A;
         "r": return 8'h0D;
         "t": return 8'h09;
         "0": return 8'h00;
         default: return c;
      endcase
   endfunction

   task automatic note(input logic [1:0] kind, input logic [7:0] data, input logic [3:0] err);
      rsp_type r;
      if (step_n < MAX_RESULTS) begin
         r.kind = kind;
         r.data_byte = (kind == KIND_BYTE) ? data : 8'h00;
         r.token_index = ((kind == KIND_BYTE || kind == KIND_END) && tok_cnt != 5'd0)
                         ? 4'(tok_cnt - 5'd1) : 4'd0;
         r.error_code = err;
         r.arg_total = (kind == KIND_DONE) ? tok_cnt : 5'd0;
         r.last_of_run = 1'b0;
         step_res[step_n] = r;
         step_n++;
      end
   endtask

   task automatic raise_error(input logic [3:0] code);
      note(KIND_ERROR, 8'h00, code);
      ph = PH_IDLE;
   endtask

   task automatic close_call();
      note(KIND_DONE, 8'h00, ERR_NONE);
      ph = PH_IDLE;
   endtask

   // Sets again when the same byte has to be parsed once more in the new phase.
   task automatic parse_byte(input logic [7:0] c, output logic again);
      logic [4:0] h;
      again = 1'b0;
      h = hex_digit(c);
      case (ph)
         PH_START: begin
            if (!blank_byte(c)) begin
               tok_cnt = 5'd1;
               if (c == CH_OPEN) begin
                  note(KIND_END, 8'h00, ERR_NONE);
                  paren_seen = 1'b1;
                  ph = PH_AFTER_NAME;
               end else begin
                  note(KIND_BYTE, c, ERR_NONE);
                  ph = PH_NAME;
               end
            end
         end
         PH_NAME: begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_OPEN) begin
               note(KIND_END, 8'h00, ERR_NONE);
               paren_seen = (c == CH_OPEN);
               ph = PH_AFTER_NAME;
            end else begin
               note(KIND_BYTE, c, ERR_NONE);
            end
         end
         PH_AFTER_NAME: begin
            if (blank_byte(c)) begin
            end else if (c == CH_OPEN) begin
               ph = PH_ARG;
            end else if (!paren_seen) begin
               raise_error(ERR_NO_PAREN);
            end else begin
               ph = PH_ARG;
               again = 1'b1;
            end
         end
         PH_ARG: begin
            if (blank_byte(c)) begin
            end else if (c == CH_CLOSE) begin
               close_call();
            end else if (tok_cnt > {1'b0, arg_limit}) begin
               raise_error(ERR_TOO_MANY);
            end else begin
               tok_cnt = tok_cnt + 5'd1;
               if (c == CH_DQUOTE) begin
                  ph = PH_STR;
               end else if (c == CH_SQUOTE) begin
                  ph = PH_CHR_OPEN;
               end else if (c == CH_COMMA) begin
                  note(KIND_END, 8'h00, ERR_NONE);
               end else begin
                  note(KIND_BYTE, c, ERR_NONE);
                  ph = PH_BARE;
               end
            end
         end
         PH_BARE: begin
            if (c == CH_SPACE || c == CH_TAB) begin
               note(KIND_END, 8'h00, ERR_NONE);
               ph = PH_AFTER_TOK;
            end else if (c == CH_COMMA) begin
               note(KIND_END, 8'h00, ERR_NONE);
               ph = PH_ARG;
            end else if (c == CH_CLOSE) begin
               note(KIND_END, 8'h00, ERR_NONE);
               close_call();
            end else begin
               note(KIND_BYTE, c, ERR_NONE);
            end
         end
         PH_AFTER_TOK: begin
            if (!blank_byte(c)) begin
               ph = PH_ARG;
               again = (c != CH_COMMA);
            end
         end
         PH_STR: begin
            if (c == CH_DQUOTE) begin
               note(KIND_END, 8'h00, ERR_NONE);
               ph = PH_AFTER_TOK;
            end else if (c == CH_BACKSLASH) begin
               ph = PH_STR_ESC;
            end else begin
               note(KIND_BYTE, c, ERR_NONE);
            end
         end
         PH_STR_ESC: begin
            if (c == CH_X) begin
               ph = PH_STR_HEX0;
            end else begin
               note(KIND_BYTE, escape_byte(c), ERR_NONE);
               ph = PH_STR;
            end
         end
         PH_STR_HEX0, PH_CHR_HEX0: begin
            if (!h[4]) begin
               raise_error(ERR_BAD_HEX);
            end else begin
               hex_acc = {4'd0, h[3:0]};
               ph = (ph == PH_STR_HEX0) ? PH_STR_HEX1 : PH_CHR_HEX1;
            end
         end
         PH_STR_HEX1: begin
            ph = PH_STR;
            if (h[4]) begin
               note(KIND_BYTE, {hex_acc[3:0], h[3:0]}, ERR_NONE);
            end else begin
               // A lone hex digit: its value is the byte, and c is parsed again.
               note(KIND_BYTE, hex_acc, ERR_NONE);
               again = 1'b1;
            end
         end
         PH_CHR_OPEN: begin
            if (c == CH_SQUOTE) begin
               raise_error(ERR_EMPTY_CHAR);
            end else if (c == CH_BACKSLASH) begin
               ph = PH_CHR_ESC;
            end else begin
               note(KIND_BYTE, c, ERR_NONE);
               ph = PH_CHR_CLOSE;
            end
         end
         PH_CHR_ESC: begin
            if (c == CH_X) begin
               ph = PH_CHR_HEX0;
            end else begin
               note(KIND_BYTE, escape_byte(c), ERR_NONE);
               ph = PH_CHR_CLOSE;
            end
         end
         PH_CHR_HEX1: begin
            if (h[4]) begin
               note(KIND_BYTE, {hex_acc[3:0], h[3:0]}, ERR_NONE);
               ph = PH_CHR_CLOSE;
            end else if (c == CH_SQUOTE) begin
               note(KIND_BYTE, hex_acc, ERR_NONE);
               note(KIND_END, 8'h00, ERR_NONE);
               ph = PH_AFTER_TOK;
            end else begin
               raise_error(ERR_BAD_CHAR);
            end
         end
         PH_CHR_CLOSE: begin
            if (c == CH_SQUOTE) begin
               note(KIND_END, 8'h00, ERR_NONE);
               ph = PH_AFTER_TOK;
            end else begin
               raise_error(ERR_BAD_CHAR);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic line_end();
      case (ph)
         PH_START: raise_error(ERR_EMPTY);
         PH_NAME: raise_error(ERR_NO_PAREN);
         PH_AFTER_NAME: raise_error(paren_seen ? ERR_NO_CLOSE : ERR_NO_PAREN);
         PH_STR, PH_STR_ESC, PH_STR_HEX0, PH_STR_HEX1: raise_error(ERR_OPEN_STRING);
         PH_IDLE: begin
         end
         default: raise_error(ERR_NO_CLOSE);
      endcase
      ph = PH_START;
      tok_cnt = 5'd0;
      hex_acc = 8'h00;
      paren_seen = 1'b0;
   endtask

   task automatic tokenize_input(input logic [7:0] c, input logic e);
      logic again;
      int   guard;
      step_n = 0;
      guard = 0;
      if (e) begin
         line_end();
      end else begin
         parse_byte(c, again);
         while (again && guard < 3) begin
            guard++;
            parse_byte(c, again);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      int      i;
      if (reset) begin
         ph = PH_START;
         tok_cnt = 5'd0;
         hex_acc = 8'h00;
         paren_seen = 1'b0;
         arg_limit = MAX_ARGS_RESET;
         token_stream_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            arg_limit = csr_max_args;
         end
         if (req_valid && !req_stall) begin
            tokenize_input(req_char_in, req_is_end);
            if (cur_typed) begin
               token_stream_q.push_back(cur_want);
            end else begin
               for (i = 0; i < step_n; i++) begin
                  want = step_res[i];
                  want.last_of_run = (i == step_n - 1);
                  token_stream_q.push_back(want);
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_kind;
            got.data_byte = rsp_data_byte;
            got.token_index = rsp_token_index;
            got.error_code = rsp_error_code;
            got.arg_total = rsp_arg_total;
            got.last_of_run = rsp_last_of_run;
            if (token_stream_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected: kind %0d data %02h idx %0d err %0d total %0d last %0d",
                           got.kind, got.data_byte, got.token_index, got.error_code,
                           got.arg_total, got.last_of_run);
               end
            end else begin
               want = token_stream_q.pop_front();
               if (got.kind != want.kind || got.data_byte != want.data_byte
                   || got.token_index != want.token_index || got.error_code != want.error_code
                   || got.arg_total != want.arg_total || got.last_of_run != want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("expected kind %0d data %02h idx %0d err %0d total %0d last %0d",
                              want.kind, want.data_byte, want.token_index, want.error_code,
                              want.arg_total, want.last_of_run);
                     $display("actual   kind %0d data %02h idx %0d err %0d total %0d last %0d",
                              got.kind, got.data_byte, got.token_index, got.error_code,
                              got.arg_total, got.last_of_run);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 24);
      end
   end

   task automatic drive(input logic [7:0] c, input logic e, input logic typed,
                        input rsp_type want);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_is_end <= e;
      cur_typed <= typed;
      cur_want <= want;
      do begin
         @(posedge clock);
      end while (req_stall);
      sent++;
   endtask

   // Lets every pending result drain, then idles on for any byte still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (token_stream_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_args(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_max_args <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic put(input logic [7:0] c, input logic e = 1'b0);
      line_byte_type b;
      b.c = c;
      b.e = e;
      line_q.push_back(b);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + {4'd0, v};
      end
      return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
   endfunction

   function automatic logic [7:0] word_byte(input logic in_arg);
      logic [7:0] b;
      do begin
         if ($urandom_range(3) != 0) begin
            b = 8'h61 + 8'($urandom_range(25));
         end else begin
            b = 8'($urandom_range(255));
         end
      end while (blank_byte(b) || b == CH_OPEN || (in_arg && (b == CH_COMMA
                 || b == CH_CLOSE || b == CH_DQUOTE || b == CH_SQUOTE)));
      return b;
   endfunction

   // One byte of a string or char literal body, plain or escaped.
   task automatic put_literal_byte(input logic in_char);
      logic [7:0] b;
      case ($urandom_range(5))
         0: begin
            put(CH_BACKSLASH);
            case ($urandom_range(3))
               0: put("n");
               1: put("r");
               2: put("t");
               default: put("0");
            endcase
         end
         1: begin
            put(CH_BACKSLASH);
            put(CH_X);
            put(hex_char(4'($urandom_range(15))));
            if ($urandom_range(1) != 0) begin
               put(hex_char(4'($urandom_range(15))));
            end
         end
         2: begin
            put(CH_BACKSLASH);
            put(8'($urandom_range(255)));
         end
         default: begin
            do begin
               b = 8'($urandom_range(255));
            end while (b == CH_BACKSLASH || b == (in_char ? CH_SQUOTE : CH_DQUOTE));
            put(b);
         end
      endcase
   endtask

   // Builds one command line: mostly well formed, some broken, some noise.
   task automatic build_line(input logic [3:0] lim);
      int mode;
      int nargs;
      int k;
      int j;
      mode = $urandom_range(99);
      line_q.delete();
      if (mode < 12) begin
         repeat ($urandom_range(1, 8)) put(8'($urandom_range(255)), $urandom_range(6) == 0);
      end else begin
         repeat ($urandom_range(2)) begin
            put(($urandom_range(1) != 0) ? CH_SPACE : 8'h09 + 8'($urandom_range(4)));
         end
         k = $urandom_range(4);
         if (k == 0) begin
            put(CH_OPEN);
            if ($urandom_range(3) == 0) put(CH_OPEN);
         end else begin
            repeat (k) put(word_byte(1'b0));
            case ($urandom_range(3))
               0: put(CH_OPEN);
               1: begin
                  put(CH_SPACE);
                  put(CH_OPEN);
               end
               2: begin
                  put(CH_OPEN);
                  put(CH_OPEN);
               end
               default: begin
                  put(CH_TAB);
                  put(CH_OPEN);
               end
            endcase
         end
         if ($urandom_range(7) == 0) begin
            nargs = int'(lim) + $urandom_range(1);
         end else begin
            nargs = $urandom_range(3);
         end
         for (k = 0; k < nargs; k++) begin
            if (k > 0) begin
               if ($urandom_range(3) == 0) put(CH_SPACE);
               put(CH_COMMA);
               if ($urandom_range(1) != 0) put(CH_SPACE);
            end
            case ($urandom_range(3))
               1: begin
                  put(CH_DQUOTE);
                  repeat ($urandom_range(4)) put_literal_byte(1'b0);
                  put(CH_DQUOTE);
               end
               2: begin
                  put(CH_SQUOTE);
                  put_literal_byte(1'b1);
                  put(CH_SQUOTE);
               end
               default: begin
                  repeat ($urandom_range(4)) put(word_byte(1'b1));
               end
            endcase
         end
         if ($urandom_range(3) == 0) put(CH_SPACE);
         put(CH_CLOSE);
         repeat ($urandom_range(2)) put(8'($urandom_range(255)));
         if (mode < 26) begin
            if ($urandom_range(1) != 0) begin
               j = $urandom_range(line_q.size() - 1);
               while (line_q.size() > j + 1) void'(line_q.pop_back());
            end else begin
               j = $urandom_range(line_q.size() - 1);
               line_q[j].c = 8'($urandom_range(255));
            end
         end
      end
      put(8'($urandom_range(255)), 1'b1);
   endtask

   initial begin : stimulus
      int         r;
      int         p;
      int         phase_end;
      logic [3:0] lim;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (r = 0; r < $size(SCRIPT); r++) begin
         drive(SCRIPT[r].c, SCRIPT[r].e, SCRIPT[r].typed, SCRIPT[r].want);
      end
      for (p = 0; p < 5; p++) begin
         settle();
         case (p)
            0: lim = 4'd1;
            1: lim = 4'd15;
            2: lim = 4'd0;
            3: lim = 4'($urandom_range(2, 14));
            default: lim = MAX_ARGS_RESET;
         endcase
         write_max_args(lim);
         // One phase runs with neither side ever idling.
         steady <= (p == 3);
         phase_end = sent + 50;
         while (sent < phase_end) begin
            build_line(lim);
            foreach (line_q[k]) begin
               drive(line_q[k].c, line_q[k].e, 1'b0, '0);
            end
         end
      end
      settle();
      if (mismatches == 0 && token_stream_q.size() == 0) begin
         $display("PASS command_call_tokenizer");
      end else begin
         $display("FAIL command_call_tokenizer");
      end
      $finish;
   end

endmodule

### sim.f
design/cct_pkg.sv
design/cct_parser.sv
design/cct_queue.sv
design/command_call_tokenizer.sv
tb/tb.sv
